### rtl/core/uartrb_pkg.sv
// Shared types, codes and helpers of the UART receive/transmit ring buffer.
// No dependencies; every other file of the block uses this package.
package uartrb_pkg;

	localparam int DEPTH_DEFAULT = 256;

	// Command queue between the front and the back part.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Action codes as they arrive on the command port.
	localparam logic [2:0] ACT_RX_ARRIVE = 3'd0;
	localparam logic [2:0] ACT_RX_READ   = 3'd1;
	localparam logic [2:0] ACT_RX_DISCARD = 3'd2;
	localparam logic [2:0] ACT_RX_FIND   = 3'd3;
	localparam logic [2:0] ACT_TX_WRITE  = 3'd4;
	localparam logic [2:0] ACT_TX_READY  = 3'd5;
	localparam logic [2:0] ACT_QUERY     = 3'd6;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef enum logic [2:0] {
		OP_RX_ARRIVE,
		OP_RX_READ,
		OP_RX_DISCARD,
		OP_RX_FIND,
		OP_TX_WRITE,
		OP_TX_READY,
		OP_QUERY
	} op_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [7:0]  data_in;
		logic [15:0] count;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] data_out;
		logic [7:0] position;
		logic [7:0] rx_level;
		logic [7:0] tx_level;
		logic       tx_active;
	} result_t;

	// Classified command as it waits in the queue.
	typedef struct packed {
		op_t         op;
		logic [7:0]  data;
		logic [15:0] count;
	} qitem_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// Levels and positions above 255 report as 255.
	function automatic logic [7:0] sat8(input logic [31:0] v);
		return (v > 32'd255) ? 8'hFF : v[7:0];
	endfunction

endpackage

### rtl/core/uartrb_front.sv
// Front part of the ring buffer: takes command transfers and classifies them.
// Depends on uartrb_pkg; feeds uartrb_cmdq.
module uartrb_front (
	input  logic                start,
	output logic                busy,
	input  uartrb_pkg::cmd_t    cmd,
	input  uartrb_pkg::qstat_t  qs,
	output logic                push,
	output uartrb_pkg::qitem_t  push_item
);

	uartrb_pkg::op_t op;

	// The unused action code behaves as a query.
	always_comb begin
		unique case (cmd.action)
			uartrb_pkg::ACT_RX_ARRIVE:  op = uartrb_pkg::OP_RX_ARRIVE;
			uartrb_pkg::ACT_RX_READ:    op = uartrb_pkg::OP_RX_READ;
			uartrb_pkg::ACT_RX_DISCARD: op = uartrb_pkg::OP_RX_DISCARD;
			uartrb_pkg::ACT_RX_FIND:    op = uartrb_pkg::OP_RX_FIND;
			uartrb_pkg::ACT_TX_WRITE:   op = uartrb_pkg::OP_TX_WRITE;
			uartrb_pkg::ACT_TX_READY:   op = uartrb_pkg::OP_TX_READY;
			default:                    op = uartrb_pkg::OP_QUERY;
		endcase
	end

	assign busy = qs.full;
	assign push = start && !qs.full;
	assign push_item = '{op: op, data: cmd.data_in, count: cmd.count};

endmodule

### rtl/core/uartrb_cmdq.sv
// Short command queue that decouples the front and back parts.
// Depends on uartrb_pkg.
module uartrb_cmdq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  uartrb_pkg::qitem_t  push_item,
	input  logic                pop,
	output uartrb_pkg::qitem_t  head,
	output uartrb_pkg::qstat_t  qs
);

	uartrb_pkg::qitem_t entry_q [uartrb_pkg::QDEPTH];
	logic [uartrb_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [uartrb_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [uartrb_pkg::QCNT_W-1:0] cnt_q;

	assign qs.full  = (cnt_q == uartrb_pkg::QCNT_W'(uartrb_pkg::QDEPTH));
	assign qs.empty = (cnt_q == '0);
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

### rtl/core/uartrb_back.sv
// Back part of the ring buffer: both ring memories, their pointers and the
// sequencer that carries out each command. Depends on uartrb_pkg.
module uartrb_back #(
	parameter int DEPTH = uartrb_pkg::DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  uartrb_pkg::qstat_t  qs,
	input  uartrb_pkg::qitem_t  head,
	output logic                pop,
	output logic                done,
	output uartrb_pkg::result_t result
);

	localparam int PW = $clog2(DEPTH);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_FIND = 3'b010,
		S_RESP = 3'b100
	} state_t;

	state_t state_q;

	logic [7:0] rx_mem [DEPTH];
	logic [7:0] tx_mem [DEPTH];
	logic [7:0] rx_rdata_q;
	logic [7:0] tx_rdata_q;

	logic [PW-1:0] rx_rd_q, rx_wr_q, rx_cnt_q;
	logic [PW-1:0] tx_rd_q, tx_wr_q, tx_cnt_q;
	logic          tx_running_q;

	logic [PW-1:0] walk_q;
	logic [PW-1:0] walk_idx_q;
	logic [7:0]    find_byte_q;
	logic [1:0]    status_q;
	logic [7:0]    pos_q;
	logic          sel_rx_q;
	logic          sel_tx_q;
	logic          done_q;
	uartrb_pkg::result_t result_q;

	logic          rx_full;
	logic          discard_all;
	logic [PW:0]   disc_sum;
	logic [PW-1:0] disc_ptr;
	logic [PW-1:0] tx_free;
	logic          tx_ok;
	logic          rx_we;
	logic          tx_we;
	logic [PW-1:0] rx_raddr;
	logic          find_hit;
	logic          find_last;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == LAST) ? '0 : p + 1'b1;
	endfunction

	assign pop = (state_q == S_IDLE) && !qs.empty;

	assign rx_full = (rx_cnt_q == LAST);
	assign discard_all = (32'(head.count) >= 32'(rx_cnt_q));
	// The count is below the level here, so one wrap correction suffices.
	assign disc_sum = {1'b0, rx_rd_q} + {1'b0, PW'(head.count)};
	assign disc_ptr = (disc_sum >= (PW+1)'(DEPTH)) ? PW'(disc_sum - (PW+1)'(DEPTH))
	                                               : PW'(disc_sum);
	assign tx_free = LAST - tx_cnt_q;
	assign tx_ok = (head.count != 16'd0) && (32'(tx_free) >= 32'(head.count));

	assign rx_we = pop && (head.op == uartrb_pkg::OP_RX_ARRIVE) && !rx_full;
	assign tx_we = pop && (head.op == uartrb_pkg::OP_TX_WRITE) && tx_ok;

	// During a search the read port runs one entry ahead of the compare.
	assign rx_raddr = (state_q == S_FIND) ? next_ptr(walk_q) : rx_rd_q;
	assign find_hit = (rx_rdata_q == find_byte_q);
	assign find_last = (walk_idx_q == rx_cnt_q - 1'b1);

	always_ff @(posedge clk) begin
		if (rx_we) begin
			rx_mem[rx_wr_q] <= head.data;
		end
		rx_rdata_q <= rx_mem[rx_raddr];
	end

	always_ff @(posedge clk) begin
		if (tx_we) begin
			tx_mem[tx_wr_q] <= head.data;
		end
		tx_rdata_q <= tx_mem[tx_rd_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rx_rd_q      <= '0;
			rx_wr_q      <= '0;
			rx_cnt_q     <= '0;
			tx_rd_q      <= '0;
			tx_wr_q      <= '0;
			tx_cnt_q     <= '0;
			tx_running_q <= 1'b0;
			walk_q       <= '0;
			walk_idx_q   <= '0;
			find_byte_q  <= '0;
			status_q     <= uartrb_pkg::ST_OK;
			pos_q        <= '0;
			sel_rx_q     <= 1'b0;
			sel_tx_q     <= 1'b0;
			done_q       <= 1'b0;
			result_q     <= '0;
		end else begin
			done_q <= (state_q == S_RESP);
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						status_q <= uartrb_pkg::ST_OK;
						pos_q    <= '0;
						sel_rx_q <= 1'b0;
						sel_tx_q <= 1'b0;
						state_q  <= S_RESP;
						unique case (head.op)
							uartrb_pkg::OP_RX_ARRIVE: begin
								if (rx_full) begin
									status_q <= uartrb_pkg::ST_FULL;
								end else begin
									rx_wr_q  <= next_ptr(rx_wr_q);
									rx_cnt_q <= rx_cnt_q + 1'b1;
								end
							end
							uartrb_pkg::OP_RX_READ: begin
								if (rx_cnt_q == '0) begin
									status_q <= uartrb_pkg::ST_EMPTY;
								end else begin
									sel_rx_q <= 1'b1;
									rx_rd_q  <= next_ptr(rx_rd_q);
									rx_cnt_q <= rx_cnt_q - 1'b1;
								end
							end
							uartrb_pkg::OP_RX_DISCARD: begin
								if (rx_cnt_q == '0) begin
									status_q <= uartrb_pkg::ST_EMPTY;
								end else if (discard_all) begin
									rx_rd_q  <= rx_wr_q;
									rx_cnt_q <= '0;
								end else begin
									rx_rd_q  <= disc_ptr;
									rx_cnt_q <= rx_cnt_q - PW'(head.count);
								end
							end
							uartrb_pkg::OP_RX_FIND: begin
								if (rx_cnt_q == '0) begin
									status_q <= uartrb_pkg::ST_EMPTY;
								end else begin
									walk_q      <= rx_rd_q;
									walk_idx_q  <= '0;
									find_byte_q <= head.data;
									state_q     <= S_FIND;
								end
							end
							uartrb_pkg::OP_TX_WRITE: begin
								if (tx_ok) begin
									tx_wr_q      <= next_ptr(tx_wr_q);
									tx_cnt_q     <= tx_cnt_q + 1'b1;
									tx_running_q <= 1'b1;
								end else begin
									status_q <= uartrb_pkg::ST_FULL;
								end
							end
							uartrb_pkg::OP_TX_READY: begin
								if (tx_cnt_q == '0) begin
									tx_running_q <= 1'b0;
									status_q     <= uartrb_pkg::ST_EMPTY;
								end else begin
									sel_tx_q <= 1'b1;
									tx_rd_q  <= next_ptr(tx_rd_q);
									tx_cnt_q <= tx_cnt_q - 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_FIND: begin
					if (find_hit) begin
						status_q <= uartrb_pkg::ST_OK;
						pos_q    <= uartrb_pkg::sat8(32'(walk_idx_q) + 32'd1);
						state_q  <= S_RESP;
					end else if (find_last) begin
						status_q <= uartrb_pkg::ST_EMPTY;
						state_q  <= S_RESP;
					end else begin
						walk_q     <= next_ptr(walk_q);
						walk_idx_q <= walk_idx_q + 1'b1;
					end
				end
				S_RESP: begin
					result_q.status    <= status_q;
					result_q.data_out  <= sel_rx_q ? rx_rdata_q : (sel_tx_q ? tx_rdata_q : 8'd0);
					result_q.position  <= pos_q;
					result_q.rx_level  <= uartrb_pkg::sat8(32'(rx_cnt_q));
					result_q.tx_level  <= uartrb_pkg::sat8(32'(tx_cnt_q));
					result_q.tx_active <= tx_running_q;
					state_q            <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule

### rtl/core/uart_rx_tx_ring_buffer.sv
// Top level of the UART receive/transmit ring buffer.
// Depends on uartrb_pkg, uartrb_front, uartrb_cmdq and uartrb_back.
//
// A command is transferred at a clock edge where start is high and busy is
// low; a two-entry queue holds commands while the back part works, and busy
// is high only while that queue is full. Each command gives exactly one
// result, shown on result for one cycle with done high, and it must be taken
// then. The back part executes each command, then forms its result, and
// takes no new command from the queue until that result is formed; a find
// also passes through a search state between the two, comparing at most as
// many entries as the receive ring holds, one entry per cycle through the
// single read port of the receive memory. Done and the result are registered
// as the result is formed. Each ring holds at most DEPTH-1 bytes.
module uart_rx_tx_ring_buffer #(
	parameter int DEPTH = uartrb_pkg::DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  uartrb_pkg::cmd_t    cmd,
	output logic                done,
	output uartrb_pkg::result_t result
);

	uartrb_pkg::qstat_t qs;
	uartrb_pkg::qitem_t push_item;
	uartrb_pkg::qitem_t head;
	logic push;
	logic pop;

	uartrb_front u_front (
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.qs        (qs),
		.push      (push),
		.push_item (push_item)
	);

	uartrb_cmdq u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.qs        (qs)
	);

	uartrb_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qs     (qs),
		.head   (head),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

	// Results never come back to back: a done pulse is always followed by done low.
	a_done_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done asserted in two consecutive cycles");

	// A failed command returns zero on data_out.
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status != uartrb_pkg::ST_OK) |-> (result.data_out == 8'd0))
		else $error("data_out nonzero on a failed command");

	// A ring never reports more than its capacity.
	a_level_cap: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(result.rx_level) <= 32'(DEPTH - 1))
		&& (32'(result.tx_level) <= 32'(DEPTH - 1)))
		else $error("ring level above capacity");

	// A found position always lies inside the ring.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.position != 8'd0) |-> (result.position <= result.rx_level)
		&& (result.status == uartrb_pkg::ST_OK))
		else $error("find position outside the receive ring");

endmodule

### tb/testbench.sv
// Self-checking testbench of uart_rx_tx_ring_buffer: directed corner cases, then random phases.
// It predicts every result from its own model of both rings and checks each field in order.
// Depends on uartrb_pkg and the uart_rx_tx_ring_buffer RTL.
module testbench;

	localparam int DEPTH = uartrb_pkg::DEPTH_DEFAULT;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int RANDOM_ITEMS = 1500;
	// Action 7 is not assigned and behaves like a query.
	localparam logic [2:0] ACT_UNUSED = 3'd7;

	typedef struct packed {
		uartrb_pkg::cmd_t c;
		logic [2:0]       gap;
		logic             drain;
	} backlog_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	uartrb_pkg::cmd_t    cmd = '0;
	logic                done;
	uartrb_pkg::result_t result;

	backlog_t            cmd_backlog[$];
	uartrb_pkg::result_t ring_results[$];
	uartrb_pkg::result_t want;
	int       idle_left = 0;
	int       mismatches = 0;
	int       cycle_count = 0;
	bit       gapless = 1'b0;
	bit       narrow = 1'b0;

	// Shadow copy of both rings.
	logic [7:0] rx_mem [DEPTH];
	logic [7:0] tx_mem [DEPTH];
	int         rx_rd = 0;
	int         rx_wr = 0;
	int         tx_rd = 0;
	int         tx_wr = 0;
	bit         tx_run = 1'b0;

	uart_rx_tx_ring_buffer #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int ring_fill(int rd, int wr);
		return (wr >= rd) ? (wr - rd) : (DEPTH - rd + wr);
	endfunction

	function automatic logic [7:0] clamp8(int v);
		return (v > 255) ? 8'hFF : v[7:0];
	endfunction

	function automatic int ring_step(int p);
		return (p + 1 >= DEPTH) ? 0 : p + 1;
	endfunction

	// Applies one command to the shadow rings and returns the result it must give.
	function automatic uartrb_pkg::result_t apply_ring_cmd(uartrb_pkg::cmd_t c);
		uartrb_pkg::result_t r;
		int      rxl;
		int      txl;
		int      p;
		rxl = ring_fill(rx_rd, rx_wr);
		txl = ring_fill(tx_rd, tx_wr);
		r = '0;
		r.status = uartrb_pkg::ST_OK;
		case (c.action)
			uartrb_pkg::ACT_RX_ARRIVE: begin
				if (rxl >= DEPTH - 1) begin
					r.status = uartrb_pkg::ST_FULL;
				end else begin
					rx_mem[rx_wr] = c.data_in;
					rx_wr = ring_step(rx_wr);
				end
			end
			uartrb_pkg::ACT_RX_READ: begin
				if (rxl == 0) begin
					r.status = uartrb_pkg::ST_EMPTY;
				end else begin
					r.data_out = rx_mem[rx_rd];
					rx_rd = ring_step(rx_rd);
				end
			end
			uartrb_pkg::ACT_RX_DISCARD: begin
				if (rxl == 0)
					r.status = uartrb_pkg::ST_EMPTY;
				else if (int'(c.count) >= rxl)
					rx_rd = rx_wr;
				else
					rx_rd = (rx_rd + int'(c.count)) % DEPTH;
			end
			uartrb_pkg::ACT_RX_FIND: begin
				r.status = uartrb_pkg::ST_EMPTY;
				p = rx_rd;
				for (int i = 0; i < rxl; i++) begin
					if (rx_mem[p] == c.data_in) begin
						r.status = uartrb_pkg::ST_OK;
						r.position = clamp8(i + 1);
						break;
					end
					p = ring_step(p);
				end
			end
			uartrb_pkg::ACT_TX_WRITE: begin
				if (c.count == 16'd0 || (DEPTH - 1 - txl) < int'(c.count)) begin
					r.status = uartrb_pkg::ST_FULL;
				end else begin
					tx_mem[tx_wr] = c.data_in;
					tx_wr = ring_step(tx_wr);
					tx_run = 1'b1;
				end
			end
			uartrb_pkg::ACT_TX_READY: begin
				if (txl == 0) begin
					tx_run = 1'b0;
					r.status = uartrb_pkg::ST_EMPTY;
				end else begin
					r.data_out = tx_mem[tx_rd];
					tx_rd = ring_step(tx_rd);
				end
			end
			default: begin
			end
		endcase
		r.rx_level = clamp8(ring_fill(rx_rd, rx_wr));
		r.tx_level = clamp8(ring_fill(tx_rd, tx_wr));
		r.tx_active = tx_run;
		return r;
	endfunction

	task automatic flag_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] exp_v);
		if (got !== exp_v)
			flag_mismatch($sformatf("%s is %0h, expected %0h", name, got, exp_v));
	endtask

	task automatic push_cmd(input logic [2:0] act, input logic [7:0] d, input logic [15:0] n,
			input bit drain);
		backlog_t b;
		b.c.action = act;
		b.c.data_in = d;
		b.c.count = n;
		b.gap = gapless ? 3'd0 : 3'($urandom_range(0, 5));
		b.drain = drain;
		cmd_backlog.push_back(b);
	endtask

	function automatic logic [7:0] pick_byte();
		return narrow ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [15:0] pick_span();
		return ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
			: 16'($urandom_range(0, 12));
	endfunction

	// Driver: one transfer per edge where start is high and busy is low.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				ring_results.push_back(apply_ring_cmd(cmd));
			if (start && busy) begin
			end else if (idle_left != 0) begin
				start <= 1'b0;
				idle_left <= idle_left - 1;
			end else if (cmd_backlog.size() != 0 &&
					!(cmd_backlog[0].drain && ring_results.size() != 0)) begin
				start <= 1'b1;
				cmd <= cmd_backlog[0].c;
				idle_left <= int'(cmd_backlog[0].gap);
				void'(cmd_backlog.pop_front());
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every strobed result is compared with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (ring_results.size() == 0) begin
				flag_mismatch("result with no command outstanding");
			end else begin
				want = ring_results.pop_front();
				check_field("status", {6'd0, result.status}, {6'd0, want.status});
				check_field("data_out", result.data_out, want.data_out);
				check_field("position", result.position, want.position);
				check_field("rx_level", result.rx_level, want.rx_level);
				check_field("tx_level", result.tx_level, want.tx_level);
				check_field("tx_active", {7'd0, result.tx_active}, {7'd0, want.tx_active});
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** uart_rx_tx_ring_buffer: FAILED **");
			$finish;
		end
	end

	initial begin
		int kind;
		int n;
		int blk;
		int target;
		// Empty rings, the unassigned action and transmit refusals.
		push_cmd(uartrb_pkg::ACT_QUERY, 8'h00, 16'h0000, 1'b0);
		push_cmd(ACT_UNUSED, 8'hFF, 16'hFFFF, 1'b0);
		push_cmd(uartrb_pkg::ACT_RX_READ, 8'h00, 16'h0000, 1'b0);
		push_cmd(uartrb_pkg::ACT_RX_DISCARD, 8'h00, 16'd5, 1'b0);
		push_cmd(uartrb_pkg::ACT_RX_FIND, 8'h00, 16'h0000, 1'b0);
		push_cmd(uartrb_pkg::ACT_TX_READY, 8'h00, 16'h0000, 1'b0);
		push_cmd(uartrb_pkg::ACT_TX_WRITE, 8'hFF, 16'd0, 1'b0);
		push_cmd(uartrb_pkg::ACT_TX_WRITE, 8'hFF, 16'hFFFF, 1'b0);
		// A block of exactly the free space fits; one byte more does not.
		push_cmd(uartrb_pkg::ACT_TX_WRITE, 8'h5A, 16'd255, 1'b0);
		push_cmd(uartrb_pkg::ACT_TX_WRITE, 8'hA5, 16'd255, 1'b0);
		push_cmd(uartrb_pkg::ACT_TX_WRITE, 8'hFF, 16'd254, 1'b0);
		push_cmd(uartrb_pkg::ACT_TX_READY, 8'h00, 16'h0000, 1'b1);
		// The search must look at the oldest byte too.
		push_cmd(uartrb_pkg::ACT_RX_ARRIVE, 8'h00, 16'h0000, 1'b0);
		push_cmd(uartrb_pkg::ACT_RX_ARRIVE, 8'hFF, 16'hFFFF, 1'b0);
		push_cmd(uartrb_pkg::ACT_RX_ARRIVE, 8'h3C, 16'h0000, 1'b0);
		push_cmd(uartrb_pkg::ACT_RX_FIND, 8'h00, 16'h0000, 1'b0);
		push_cmd(uartrb_pkg::ACT_RX_FIND, 8'h3C, 16'h0000, 1'b0);
		push_cmd(uartrb_pkg::ACT_RX_FIND, 8'h81, 16'h0000, 1'b0);
		push_cmd(uartrb_pkg::ACT_RX_DISCARD, 8'h00, 16'd0, 1'b0);
		push_cmd(uartrb_pkg::ACT_RX_READ, 8'h00, 16'h0000, 1'b0);
		push_cmd(uartrb_pkg::ACT_RX_DISCARD, 8'h00, 16'hFFFF, 1'b0);
		push_cmd(uartrb_pkg::ACT_TX_READY, 8'h00, 16'h0000, 1'b0);
		push_cmd(uartrb_pkg::ACT_TX_READY, 8'h00, 16'h0000, 1'b0);
		push_cmd(uartrb_pkg::ACT_QUERY, 8'hFF, 16'hFFFF, 1'b1);

		target = cmd_backlog.size() + RANDOM_ITEMS;
		while (cmd_backlog.size() < target) begin
			kind = $urandom_range(0, 4);
			gapless = ($urandom_range(0, 3) == 0);
			narrow = ($urandom_range(0, 1) == 0);
			n = $urandom_range(40, 300);
			push_cmd(uartrb_pkg::ACT_QUERY, pick_byte(), pick_span(),
				$urandom_range(0, 2) == 0);
			case (kind)
				0: begin
					// Mostly arrivals, so the receive ring fills up and overflows.
					repeat (n) begin
						case ($urandom_range(0, 19))
							0, 1: push_cmd(uartrb_pkg::ACT_RX_FIND, pick_byte(), pick_span(),
								1'b0);
							2: push_cmd(uartrb_pkg::ACT_RX_READ, pick_byte(), pick_span(),
								1'b0);
							default: push_cmd(uartrb_pkg::ACT_RX_ARRIVE, pick_byte(),
								pick_span(), 1'b0);
						endcase
					end
				end
				1: begin
					repeat (n / 2) begin
						case ($urandom_range(0, 9))
							0, 1, 2, 3: push_cmd(uartrb_pkg::ACT_RX_READ, pick_byte(),
								pick_span(), 1'b0);
							4, 5: push_cmd(uartrb_pkg::ACT_RX_DISCARD, pick_byte(),
								pick_span(), 1'b0);
							6, 7: push_cmd(uartrb_pkg::ACT_RX_FIND, pick_byte(), pick_span(),
								1'b0);
							default: push_cmd(uartrb_pkg::ACT_RX_ARRIVE, pick_byte(),
								pick_span(), 1'b0);
						endcase
					end
				end
				2: begin
					// Write blocks with a falling pending count, as software sends them.
					repeat ($urandom_range(1, 6)) begin
						blk = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
							: $urandom_range(1, 24);
						for (int k = blk; k >= 1; k--) begin
							push_cmd(uartrb_pkg::ACT_TX_WRITE, pick_byte(), 16'(k), 1'b0);
							if ($urandom_range(0, 3) == 0)
								push_cmd(uartrb_pkg::ACT_TX_READY, pick_byte(), pick_span(),
									1'b0);
						end
					end
				end
				3: begin
					repeat (n / 3) begin
						push_cmd(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
							16'($urandom_range(0, 65535)), 1'b0);
					end
				end
				default: begin
					repeat (n / 2) begin
						if ($urandom_range(0, 5) == 0)
							push_cmd(uartrb_pkg::ACT_TX_WRITE, pick_byte(), pick_span(), 1'b0);
						else
							push_cmd(uartrb_pkg::ACT_TX_READY, pick_byte(), pick_span(), 1'b0);
					end
				end
			endcase
		end
		// A long last phase would overshoot the item count, so trim it back.
		while (cmd_backlog.size() > target)
			void'(cmd_backlog.pop_back());

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		while (cmd_backlog.size() != 0 || start || ring_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("** uart_rx_tx_ring_buffer: PASSED **");
		else
			$display("** uart_rx_tx_ring_buffer: FAILED **");
		$finish;
	end

endmodule
